// File: src/bsc_pkg.sv
// Shared types and constants for the bubble sort block with swap count.
// Used by the channel interfaces, the sorting cell and the top level.
package bsc_pkg;

	// Default number of values in one set.
	localparam int SET_SIZE_DEF = 16;

	// Field widths.
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;

	// Largest swap count that can be reported; the total saturates here.
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Controls broadcast from the sequencer to every cell of the chain.
	typedef struct packed {
		logic load;   // insert the incoming sample
		logic shift;  // move every value one place towards the output
	} cell_ctl_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EMIT = 2'b10
	} seq_state_t;

endpackage

// File: src/bsc_in_if.sv
// Input channel: one signed sample per transfer.
// Depends on bsc_pkg for the data width.
interface bsc_in_if import bsc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// File: src/bsc_out_if.sv
// Output channel: one sorted value with the set's swap count per transfer.
// Depends on bsc_pkg for the field widths.
interface bsc_out_if import bsc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sorted_value;
	logic [COUNT_W-1:0]       swap_count;
	logic                     already_sorted;
	logic                     last_out;

	modport source (output valid, output sorted_value, output swap_count,
		output already_sorted, output last_out, input ready);
	modport sink   (input valid, input sorted_value, input swap_count,
		input already_sorted, input last_out, output ready);
endinterface

// File: src/bubble_sort_with_swap_count.sv
// Bubble sort with swap count: a chain of SET_SIZE insertion cells.
// Loading takes one sample per cycle; each sample is placed in the chain at the clock edge that accepts it.
// After the last sample of a set, SET_SIZE results follow, one per cycle
// while the sink is ready, shifted out of the chain.
// No sample is taken while results are emitted.
// Reset (asynchronous, active low) empties the chain and clears the count.
module bubble_sort_with_swap_count import bsc_pkg::*; #(
	parameter int SET_SIZE = SET_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bsc_in_if.sink    sample_ch,
	bsc_out_if.source result_ch
);

	localparam int CNT_W = $clog2(SET_SIZE + 1);
	localparam int IDX_W = $clog2(SET_SIZE);
	localparam int SUM_W = COUNT_W + 1;

	seq_state_t               state_q;
	logic [CNT_W-1:0]         filled_q;
	logic [COUNT_W-1:0]       total_q;
	cell_ctl_t                ctl;
	logic                     in_xfer;
	logic                     out_xfer;
	logic                     last_cell;
	logic signed [DATA_W-1:0] chain_value [0:SET_SIZE+1];
	logic                     chain_valid [0:SET_SIZE+1];
	logic                     chain_gt    [0:SET_SIZE];
	logic [IDX_W-1:0]         ins_pos;
	logic                     any_gt;
	logic [IDX_W-1:0]         inc;
	logic [SUM_W-1:0]         sum;

	assign in_xfer  = sample_ch.valid && sample_ch.ready;
	assign out_xfer = result_ch.valid && result_ch.ready;

	assign ctl.load  = in_xfer;
	assign ctl.shift = out_xfer;

	// Chain boundaries: below the first cell and above the last.
	assign chain_value[0]          = '0;
	assign chain_valid[0]          = 1'b1;
	assign chain_gt[0]             = 1'b0;
	assign chain_value[SET_SIZE+1] = '0;
	assign chain_valid[SET_SIZE+1] = 1'b0;

	// The cells, smallest value at the bottom.
	for (genvar i = 1; i <= SET_SIZE; i++) begin : g_cell
		bsc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.sample     (sample_ch.sample),
			.prev_value (chain_value[i-1]),
			.prev_valid (chain_valid[i-1]),
			.prev_gt    (chain_gt[i-1]),
			.next_value (chain_value[i+1]),
			.next_valid (chain_valid[i+1]),
			.value      (chain_value[i]),
			.valid      (chain_valid[i]),
			.gt         (chain_gt[i])
		);
	end

	// The greater cells form a run at the top of the filled part; find its start.
	always_comb begin
		ins_pos = '0;
		any_gt  = 1'b0;
		for (int i = 0; i < SET_SIZE; i++) begin
			if (chain_gt[i+1] && !chain_gt[i]) begin
				ins_pos = ins_pos | IDX_W'(i);
				any_gt  = 1'b1;
			end
		end
	end

	// Values moved up by this sample, added to a saturating total.
	assign inc = any_gt ? IDX_W'(filled_q - CNT_W'(ins_pos)) : '0;
	assign sum = SUM_W'(total_q) + SUM_W'(inc);

	// Sequencer: load a full set, then shift it out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			filled_q <= '0;
			total_q  <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						total_q <= (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX
							: sum[COUNT_W-1:0];
						if (filled_q == CNT_W'(SET_SIZE - 1)) begin
							filled_q <= '0;
							state_q  <= ST_EMIT;
						end else begin
							filled_q <= filled_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (out_xfer && last_cell) begin
						total_q <= '0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// The bottom cell is the last one once the cell above it has drained.
	assign last_cell = !chain_valid[2];

	assign sample_ch.ready          = (state_q == ST_LOAD);
	assign result_ch.valid          = (state_q == ST_EMIT);
	assign result_ch.sorted_value   = chain_value[1];
	assign result_ch.swap_count     = total_q;
	assign result_ch.already_sorted = (total_q == '0);
	assign result_ch.last_out       = last_cell;

endmodule

// File: src/bsc_cell.sv
// One cell of the insertion chain: holds one value and its valid bit.
// Depends on bsc_pkg for the data width and the control struct.
module bsc_cell import bsc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] sample,
	input  logic signed [DATA_W-1:0] prev_value,
	input  logic                     prev_valid,
	input  logic                     prev_gt,
	input  logic signed [DATA_W-1:0] next_value,
	input  logic                     next_valid,
	output logic signed [DATA_W-1:0] value,
	output logic                     valid,
	output logic                     gt
);

	logic signed [DATA_W-1:0] value_q;
	logic                     valid_q;
	logic                     take;

	// The stored value is strictly greater than the incoming sample.
	assign gt = valid_q && (value_q > sample);

	// A greater cell moves up; the first empty cell takes the overflow.
	assign take = gt || (!valid_q && prev_valid);

	// Valid bits fill from the bottom on insertion and drain on shift out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= valid_q || prev_valid;
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end
	end

	// Payload: lower value if it moves up, else sample; upper value on shift.
	always_ff @(posedge clk) begin
		if (ctl.load && take) begin
			value_q <= prev_gt ? prev_value : sample;
		end else if (ctl.shift) begin
			value_q <= next_value;
		end
	end

	assign value = value_q;
	assign valid = valid_q;

endmodule

// File: test/bubble_sort_with_swap_count_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for bubble_sort_with_swap_count at its default set size.
// Depends on bsc_pkg, bsc_in_if, bsc_out_if and the top level of the block.
module bubble_sort_with_swap_count_test;
	import bsc_pkg::*;

	localparam int SET_SIZE = SET_SIZE_DEF;
	localparam int RANDOM_SETS = 14;
	localparam int unsigned PHASE_LEN = 80;
	localparam int unsigned HOLD_AT = 40;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int CHK_W = DATA_W + 1;

	// One sorted value together with the statistics of its set.
	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic [COUNT_W-1:0]       swap_count;
		logic                     already_sorted;
		logic                     last_out;
	} sort_result_t;

	// Kinds of value set used by the random part.
	typedef enum int unsigned {
		SHAPE_RANDOM,
		SHAPE_ASCENDING,
		SHAPE_DESCENDING,
		SHAPE_NEAR_SORTED,
		SHAPE_FEW_VALUES,
		SHAPE_EXTREMES
	} set_shape_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bsc_in_if  smp_ch ();
	bsc_out_if res_ch ();

	bubble_sort_with_swap_count #(.SET_SIZE(SET_SIZE)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (smp_ch),
		.result_ch (res_ch)
	);

	logic signed [DATA_W-1:0] pending_samples [$];
	sort_result_t             sorted_expect [$];
	sort_result_t             oldest_result;

	// Own copy of the insertion chain, used to predict each set.
	logic signed [DATA_W-1:0] chain_vals [SET_SIZE];
	int unsigned              chain_fill = 0;
	int unsigned              chain_swaps = 0;

	int unsigned taken_cnt = 0;
	int unsigned fail_cnt = 0;
	int unsigned quiet_cycles = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	int unsigned src_gap_pct;
	int unsigned snk_gap_pct;

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Places one sample in the chain; the sample that completes the set
	// releases the whole set in ascending order.
	function automatic void insert_sample(input logic signed [DATA_W-1:0] value);
		int unsigned slot;
		int unsigned k;
		sort_result_t r;
		if (chain_fill >= SET_SIZE)
			chain_fill = 0;
		slot = chain_fill;
		// Only strictly greater values move up; equal values stay put.
		while (slot > 0 && chain_vals[slot-1] > value) begin
			chain_vals[slot] = chain_vals[slot-1];
			slot--;
			if (chain_swaps < COUNT_MAX)
				chain_swaps++;
		end
		chain_vals[slot] = value;
		chain_fill++;
		if (chain_fill == SET_SIZE) begin
			for (k = 0; k < SET_SIZE; k++) begin
				r.sorted_value   = chain_vals[k];
				r.swap_count     = chain_swaps[COUNT_W-1:0];
				r.already_sorted = (chain_swaps == 0);
				r.last_out       = (k == SET_SIZE - 1);
				sorted_expect.push_back(r);
			end
			chain_fill = 0;
			chain_swaps = 0;
		end
	endfunction

	// Compares one field of a result and logs any difference.
	function automatic void check_field(input string field,
		input logic signed [CHK_W-1:0] want, input logic signed [CHK_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			fail_cnt++;
		end
	endfunction

	// Builds one complete set of the given kind and queues it for the driver.
	task automatic queue_set(input set_shape_t shape);
		logic signed [DATA_W-1:0] vals [SET_SIZE];
		logic signed [DATA_W-1:0] tmp;
		longint level;
		int unsigned k;
		int unsigned j;
		case (shape)
			SHAPE_ASCENDING, SHAPE_NEAR_SORTED: begin
				level = -64'sd2147483648 + longint'($urandom_range(0, 32'h8000_0000));
				for (k = 0; k < SET_SIZE; k++) begin
					vals[k] = level[DATA_W-1:0];
					level += longint'($urandom_range(0, 32'h0400_0000));
				end
				if (shape == SHAPE_NEAR_SORTED) begin
					j = $urandom_range(0, SET_SIZE - 2);
					tmp = vals[j];
					vals[j] = vals[j+1];
					vals[j+1] = tmp;
				end
			end
			SHAPE_DESCENDING: begin
				// Strictly falling, so every pair is an inversion.
				level = 64'sd2147483647 - longint'($urandom_range(0, 32'h8000_0000));
				for (k = 0; k < SET_SIZE; k++) begin
					vals[k] = level[DATA_W-1:0];
					level -= longint'($urandom_range(1, 32'h0400_0000));
				end
			end
			SHAPE_FEW_VALUES: begin
				for (k = 0; k < SET_SIZE; k++)
					vals[k] = $urandom_range(0, 3) - 2;
			end
			SHAPE_EXTREMES: begin
				for (k = 0; k < SET_SIZE; k++) begin
					case ($urandom_range(0, 4))
						0: vals[k] = 32'h8000_0000;
						1: vals[k] = 32'h7FFF_FFFF;
						2: vals[k] = -1;
						3: vals[k] = 0;
						default: vals[k] = 1;
					endcase
				end
			end
			default: begin
				for (k = 0; k < SET_SIZE; k++)
					vals[k] = $urandom();
			end
		endcase
		for (k = 0; k < SET_SIZE; k++)
			pending_samples.push_back(vals[k]);
	endtask

	// Idle rates per phase: sender light and receiver heavy, then swapped, then none.
	always @* begin
		if (taken_cnt < PHASE_LEN) begin
			src_gap_pct = 18;
			snk_gap_pct = 63;
		end else if (taken_cnt < 2 * PHASE_LEN) begin
			src_gap_pct = 63;
			snk_gap_pct = 18;
		end else begin
			src_gap_pct = 0;
			snk_gap_pct = 0;
		end
	end

	// Sample driver: each accepted transfer feeds the predictor, then the next
	// sample is offered unless the sender chooses to idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_ch.valid <= 1'b0;
			smp_ch.sample <= '0;
		end else begin
			if (smp_ch.valid && smp_ch.ready) begin
				insert_sample(smp_ch.sample);
				taken_cnt <= taken_cnt + 1;
			end
			if (!smp_ch.valid || smp_ch.ready) begin
				if (pending_samples.size() != 0 && $urandom_range(0, 99) >= src_gap_pct) begin
					smp_ch.valid <= 1'b1;
					smp_ch.sample <= pending_samples.pop_front();
				end else begin
					smp_ch.valid <= 1'b0;
				end
			end
		end
	end

	// One long receiver hold-off, so that the chain fills and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && taken_cnt >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result monitor: checks each transfer against the oldest expected result
	// and drives ready with random stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (sorted_expect.size() == 0) begin
					$display("%0t: unexpected result, expected none, got sorted_value %0d",
						$time, res_ch.sorted_value);
					fail_cnt++;
				end else begin
					oldest_result = sorted_expect.pop_front();
					check_field("sorted_value", CHK_W'(oldest_result.sorted_value),
						CHK_W'(res_ch.sorted_value));
					check_field("swap_count", CHK_W'(oldest_result.swap_count),
						CHK_W'(res_ch.swap_count));
					check_field("already_sorted", CHK_W'(oldest_result.already_sorted),
						CHK_W'(res_ch.already_sorted));
					check_field("last_out", CHK_W'(oldest_result.last_out),
						CHK_W'(res_ch.last_out));
				end
			end
			res_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= snk_gap_pct);
		end
	end

	// Counts cycles without any transfer on either channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Watchdog: the run is abandoned when traffic stops for too long.
	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("bubble_sort_with_swap_count regression: fail");
		$finish;
	end

	// Stimulus and end of run.
	initial begin
		logic signed [DATA_W-1:0] boundary_vals [16];
		int unsigned k;

		// Directed set: already ascending, with both extremes and repeated values.
		boundary_vals = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0001, -65536,
			-2, -1, -1, 0, 0, 1, 2, 255, 32'h0001_0000, 32'h7FFF_FFFE,
			32'h7FFF_FFFF, 32'h7FFF_FFFF};
		for (k = 0; k < 16; k++)
			pending_samples.push_back(boundary_vals[k]);

		// Random sets; the first is strictly falling for the largest swap count.
		queue_set(SHAPE_DESCENDING);
		for (k = 1; k < RANDOM_SETS; k++)
			queue_set(set_shape_t'($urandom_range(0, 5)));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_samples.size() != 0 || smp_ch.valid || sorted_expect.size() != 0)
			@(posedge clk);
		repeat (2 * SET_SIZE + 4) @(posedge clk);

		if (fail_cnt == 0 && sorted_expect.size() == 0)
			$display("bubble_sort_with_swap_count regression: pass");
		else
			$display("bubble_sort_with_swap_count regression: fail");
		$finish;
	end

endmodule

// File: bubble_sort_with_swap_count.f
src/bsc_pkg.sv
src/bsc_in_if.sv
src/bsc_out_if.sv
src/bsc_cell.sv
src/bubble_sort_with_swap_count.sv
test/bubble_sort_with_swap_count_test.sv
